// ===== rtl/crc_framed_link_codec_top_defines.svh =====
// Assertion macros for the link codec RTL, used by cflc_seq.
// CFLC_ASSERT_CLK takes an explicit clock and active-low reset.
// CFLC_ASSERT uses the block's clk_i and rst_ni.
`ifndef CRC_FRAMED_LINK_CODEC_TOP_DEFINES_SVH
`define CRC_FRAMED_LINK_CODEC_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CFLC_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("link codec assertion failed");
`define CFLC_ASSERT(label, prop) \
  `CFLC_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define CFLC_ASSERT_CLK(label, clk, rst_n, prop)
`define CFLC_ASSERT(label, prop)
`endif

`endif

// ===== rtl/cflc_pkg.sv =====
`default_nettype none

package cflc_pkg;

  localparam int unsigned LengthBitsDef = 10;
  localparam int unsigned PlenW         = 10;

  localparam logic [15:0] CrcStart = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [7:0]  DirSend  = 8'h7F;
  localparam logic [7:0]  DirRecv  = 8'hFF;

  typedef enum logic [1:0] {
    OP_SEND_START = 2'd0,
    OP_SEND_BYTE  = 2'd1,
    OP_RECV_START = 2'd2,
    OP_RECV_BYTE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_DIR     = 3'd0,
    KIND_HDR_HI  = 3'd1,
    KIND_HDR_LO  = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_CRC_HI  = 3'd4,
    KIND_CRC_LO  = 3'd5
  } kind_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] header_word;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    kind_e            byte_kind;
    logic             is_receive;
    logic [PlenW-1:0] payload_length;
    logic             more_fragments;
    logic             frame_end;
    logic             crc_bad;
    logic             last;
  } result_t;

  // One byte through the CRC register, most significant bit first.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cflc_in_stage.sv =====
`default_nettype none

module cflc_in_stage import cflc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire item_t in_data_i,
  input  wire logic  take_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // The register frees itself in the cycle its item is finished.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== rtl/cflc_seq.sv =====
`default_nettype none

`include "crc_framed_link_codec_top_defines.svh"

module cflc_seq import cflc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  input  wire logic  out_ready_i,
  output logic       take_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam logic [15:0] LenMask = 16'((32'd1 << LENGTH_BITS) - 32'd1);

  // Frame phase codes.
  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhHdrHi   = 3'd1;
  localparam logic [2:0] PhHdrLo   = 3'd2;
  localparam logic [2:0] PhPayload = 3'd3;
  localparam logic [2:0] PhCrcHi   = 3'd4;
  localparam logic [2:0] PhCrcLo   = 3'd5;

  // Emission steps within one item.
  localparam logic [2:0] StFirst = 3'd0;
  localparam logic [2:0] StHdrHi = 3'd1;
  localparam logic [2:0] StHdrLo = 3'd2;
  localparam logic [2:0] StCrcHi = 3'd3;
  localparam logic [2:0] StCrcLo = 3'd4;

  logic [15:0]            crc_q, crc_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [2:0]             phase_q, phase_d;
  logic                   recv_q, recv_d;
  logic [7:0]             hold_q, hold_d;
  logic [2:0]             step_q, step_d, step_nx;

  logic        emit, done, fire;
  result_t     res;
  logic [15:0] crc_nx;
  logic [15:0] hdr_rx;
  logic [7:0]  d;

  assign d      = item_i.data_byte;
  assign hdr_rx = {hold_q, d};

  always_comb begin
    crc_d   = crc_q;
    rem_d   = rem_q;
    phase_d = phase_q;
    recv_d  = recv_q;
    hold_d  = hold_q;
    step_nx = StFirst;
    emit    = 1'b0;
    done    = 1'b1;
    crc_nx  = crc_byte(crc_q, d);
    res     = '0;

    case (step_q)
      StFirst: begin
        case (item_i.op)
          OP_SEND_START: begin
            recv_d        = 1'b0;
            crc_d         = CrcStart;
            emit          = 1'b1;
            res.out_byte  = DirSend;
            res.byte_kind = KIND_DIR;
            done          = 1'b0;
            step_nx       = StHdrHi;
          end
          OP_SEND_BYTE: begin
            if (!recv_q && phase_q == PhPayload && rem_q != '0) begin
              emit          = 1'b1;
              res.out_byte  = d;
              res.byte_kind = KIND_PAYLOAD;
              crc_d         = crc_nx;
              rem_d         = rem_q - LENGTH_BITS'(1);
              if (rem_d == '0) begin
                done    = 1'b0;
                step_nx = StCrcHi;
              end else begin
                res.last = 1'b1;
              end
            end
          end
          OP_RECV_START: begin
            recv_d         = 1'b1;
            crc_d          = CrcStart;
            rem_d          = '0;
            phase_d        = PhHdrHi;
            emit           = 1'b1;
            res.out_byte   = DirRecv;
            res.byte_kind  = KIND_DIR;
            res.is_receive = 1'b1;
            res.last       = 1'b1;
          end
          OP_RECV_BYTE: begin
            if (recv_q) begin
              res.out_byte   = d;
              res.is_receive = 1'b1;
              res.last       = 1'b1;
              case (phase_q)
                PhHdrHi: begin
                  emit          = 1'b1;
                  crc_d         = crc_nx;
                  hold_d        = d;
                  res.byte_kind = KIND_HDR_HI;
                  phase_d       = PhHdrLo;
                end
                PhHdrLo: begin
                  emit               = 1'b1;
                  crc_d              = crc_nx;
                  rem_d              = hdr_rx[LENGTH_BITS-1:0];
                  res.byte_kind      = KIND_HDR_LO;
                  res.payload_length = PlenW'(hdr_rx & LenMask);
                  res.more_fragments = hdr_rx[10];
                  phase_d            = (rem_d != '0) ? PhPayload : PhCrcHi;
                end
                PhPayload: begin
                  emit          = 1'b1;
                  crc_d         = crc_nx;
                  res.byte_kind = KIND_PAYLOAD;
                  rem_d         = rem_q - LENGTH_BITS'(1);
                  if (rem_d == '0) begin
                    phase_d = PhCrcHi;
                  end
                end
                PhCrcHi: begin
                  emit          = 1'b1;
                  crc_d         = crc_nx;
                  res.byte_kind = KIND_CRC_HI;
                  phase_d       = PhCrcLo;
                end
                PhCrcLo: begin
                  emit          = 1'b1;
                  crc_d         = crc_nx;
                  res.byte_kind = KIND_CRC_LO;
                  res.frame_end = 1'b1;
                  res.crc_bad   = (crc_nx != 16'h0000);
                  phase_d       = PhIdle;
                  recv_d        = 1'b0;
                end
                default: begin
                  res = '0;
                end
              endcase
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
      StHdrHi: begin
        emit          = 1'b1;
        res.out_byte  = item_i.header_word[15:8];
        res.byte_kind = KIND_HDR_HI;
        crc_d         = crc_byte(crc_q, item_i.header_word[15:8]);
        done          = 1'b0;
        step_nx       = StHdrLo;
      end
      StHdrLo: begin
        emit          = 1'b1;
        res.out_byte  = item_i.header_word[7:0];
        res.byte_kind = KIND_HDR_LO;
        crc_d         = crc_byte(crc_q, item_i.header_word[7:0]);
        rem_d         = item_i.header_word[LENGTH_BITS-1:0];
        phase_d       = PhPayload;
        if (rem_d == '0) begin
          done    = 1'b0;
          step_nx = StCrcHi;
        end else begin
          res.last = 1'b1;
        end
      end
      StCrcHi: begin
        emit          = 1'b1;
        res.out_byte  = crc_q[15:8];
        res.byte_kind = KIND_CRC_HI;
        crc_d         = crc_byte(crc_q, crc_q[15:8]);
        done          = 1'b0;
        step_nx       = StCrcLo;
      end
      StCrcLo: begin
        // Folding in the high byte leaves the low byte in the upper half.
        emit          = 1'b1;
        res.out_byte  = crc_q[15:8];
        res.byte_kind = KIND_CRC_LO;
        res.frame_end = 1'b1;
        res.last      = 1'b1;
        crc_d         = crc_byte(crc_q, crc_q[15:8]);
        phase_d       = PhIdle;
        rem_d         = '0;
      end
      default: begin
        step_nx = StFirst;
      end
    endcase
  end

  // A byte-producing step waits for room in the output register.
  assign fire        = item_valid_i && (!emit || out_ready_i);
  assign take_o      = fire && done;
  assign res_valid_o = item_valid_i && emit;
  assign res_o       = res;
  assign step_d      = done ? StFirst : step_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcStart;
      rem_q   <= '0;
      phase_q <= PhIdle;
      recv_q  <= 1'b0;
      hold_q  <= '0;
      step_q  <= StFirst;
    end else if (fire) begin
      crc_q   <= crc_d;
      rem_q   <= rem_d;
      phase_q <= phase_d;
      recv_q  <= recv_d;
      hold_q  <= hold_d;
      step_q  <= step_d;
    end
  end

  `CFLC_ASSERT(a_multi_step_holds_item, (step_q != StFirst) |-> item_valid_i)
  `CFLC_ASSERT(a_send_crc_residue_zero,
               (fire && step_q == StCrcLo) |=> (crc_q == 16'h0000 && phase_q == PhIdle))
  `CFLC_ASSERT(a_receive_has_phase, recv_q |-> (phase_q != PhIdle))
  `CFLC_ASSERT(a_send_steps_not_receiving, (step_q != StFirst) |-> !recv_q)

endmodule

`default_nettype wire

// ===== rtl/cflc_out_stage.sv =====
`default_nettype none

module cflc_out_stage import cflc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    res_valid_i,
  input  wire result_t res_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      out_data_o
);

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  // Free when empty or when the held byte leaves in this cycle.
  assign ready_o = !valid_q || !out_stall_i;
  assign load    = res_valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

// ===== rtl/crc_framed_link_codec_top.sv =====
// An item waits in the input register, and each byte it yields in the output register.
// Throughput: up to one output byte per cycle while out_stall_i is low. An item
// yields one byte for most ops, three for a send start or a closing payload byte
// and five for an empty send; an item that yields no byte is still taken.
// Reset (rst_ni low, asynchronous) empties both registers, sets the CRC to all ones
// and returns the framer to idle, not receiving, with a zero length count.
`default_nettype none

module crc_framed_link_codec_top import cflc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire item_t in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output result_t    out_data_o
);

  // The block is three parts in a row. The input register takes one transfer and
  // holds it while the sequencer walks through the bytes that it causes; it
  // frees itself in the very cycle the last byte is handed on, so a new item can
  // follow without a gap. The sequencer keeps the framing state (CRC register,
  // remaining length, phase, direction and the held header byte) and produces one
  // byte per cycle while the output register has room, with one CRC byte update in
  // its path. The output register parts the sequencer from the receiving side; while
  // a finished byte waits to be taken, steps that produce a byte wait as well.

  logic    item_valid;
  item_t   item;
  logic    take;
  logic    res_valid;
  result_t res;
  logic    out_ready;

  cflc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .take_i      (take),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  // Sending frames add the direction byte, the header and the trailing CRC;
  // receiving frames classify and echo each byte and judge the residue at the end.
  cflc_seq #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .out_ready_i (out_ready),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cflc_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/link_byte_checker.sv =====
// Watches both channels of the link codec, predicts the link bytes that each
// accepted item should produce and compares them in order with what comes out.
module link_byte_checker import cflc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_stall_i,
  input  item_t   in_item_i,
  input  logic    out_valid_i,
  input  logic    out_stall_i,
  input  result_t out_result_i,
  output int      mismatches_o,
  output int      outstanding_o,
  output int      checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR_HI,
    PH_HDR_LO,
    PH_PAYLOAD,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_e;

  result_t          expected_bytes[$];
  logic [15:0]      crc_acc;
  logic [PlenW-1:0] len_left;
  phase_e           phase;
  logic             rx_mode;
  logic [7:0]       hdr_hi_hold;
  int               produced;

  // Bit-serial form of the CCITT register: each data bit is folded into the top.
  function automatic logic [15:0] crc_advance(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    int k;
    r = acc;
    for (k = 7; k >= 0; k--) begin
      if (r[15] ^ b[k]) begin
        r = {r[14:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  task automatic push_byte(logic [7:0] b, kind_e kind, logic rx, logic [PlenW-1:0] plen,
                           logic more, logic fend, logic bad);
    result_t r;
    r.out_byte       = b;
    r.byte_kind      = kind;
    r.is_receive     = rx;
    r.payload_length = plen;
    r.more_fragments = more;
    r.frame_end      = fend;
    r.crc_bad        = bad;
    r.last           = 1'b0;
    expected_bytes.push_back(r);
    produced++;
  endtask

  // The CRC bytes of a sent frame come from the register before either is folded in.
  task automatic close_send_frame();
    logic [15:0] snap;
    snap = crc_acc;
    push_byte(snap[15:8], KIND_CRC_HI, 1'b0, '0, 1'b0, 1'b0, 1'b0);
    crc_acc = crc_advance(crc_acc, snap[15:8]);
    push_byte(snap[7:0], KIND_CRC_LO, 1'b0, '0, 1'b0, 1'b1, 1'b0);
    crc_acc = crc_advance(crc_acc, snap[7:0]);
    phase    = PH_IDLE;
    len_left = '0;
  endtask

  task automatic predict_link_bytes(item_t it);
    logic [15:0] h;
    produced = 0;
    case (it.op)
      OP_SEND_START: begin
        rx_mode = 1'b0;
        push_byte(DirSend, KIND_DIR, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        crc_acc = CrcStart;
        push_byte(it.header_word[15:8], KIND_HDR_HI, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        crc_acc = crc_advance(crc_acc, it.header_word[15:8]);
        push_byte(it.header_word[7:0], KIND_HDR_LO, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        crc_acc  = crc_advance(crc_acc, it.header_word[7:0]);
        len_left = it.header_word[PlenW-1:0];
        phase    = PH_PAYLOAD;
        if (len_left == '0) close_send_frame();
      end
      OP_SEND_BYTE: begin
        if (!rx_mode && phase == PH_PAYLOAD && len_left != '0) begin
          push_byte(it.data_byte, KIND_PAYLOAD, 1'b0, '0, 1'b0, 1'b0, 1'b0);
          crc_acc  = crc_advance(crc_acc, it.data_byte);
          len_left = len_left - PlenW'(1);
          if (len_left == '0) close_send_frame();
        end
      end
      OP_RECV_START: begin
        rx_mode = 1'b1;
        push_byte(DirRecv, KIND_DIR, 1'b1, '0, 1'b0, 1'b0, 1'b0);
        crc_acc  = CrcStart;
        len_left = '0;
        phase    = PH_HDR_HI;
      end
      default: begin
        if (rx_mode) begin
          case (phase)
            PH_HDR_HI: begin
              crc_acc     = crc_advance(crc_acc, it.data_byte);
              hdr_hi_hold = it.data_byte;
              push_byte(it.data_byte, KIND_HDR_HI, 1'b1, '0, 1'b0, 1'b0, 1'b0);
              phase = PH_HDR_LO;
            end
            PH_HDR_LO: begin
              h        = {hdr_hi_hold, it.data_byte};
              crc_acc  = crc_advance(crc_acc, it.data_byte);
              len_left = h[PlenW-1:0];
              push_byte(it.data_byte, KIND_HDR_LO, 1'b1, len_left, h[10], 1'b0, 1'b0);
              phase = (len_left != '0) ? PH_PAYLOAD : PH_CRC_HI;
            end
            PH_PAYLOAD: begin
              crc_acc = crc_advance(crc_acc, it.data_byte);
              push_byte(it.data_byte, KIND_PAYLOAD, 1'b1, '0, 1'b0, 1'b0, 1'b0);
              len_left = len_left - PlenW'(1);
              if (len_left == '0) phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
              crc_acc = crc_advance(crc_acc, it.data_byte);
              push_byte(it.data_byte, KIND_CRC_HI, 1'b1, '0, 1'b0, 1'b0, 1'b0);
              phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
              crc_acc = crc_advance(crc_acc, it.data_byte);
              push_byte(it.data_byte, KIND_CRC_LO, 1'b1, '0, 1'b0, 1'b1, crc_acc != 16'h0000);
              phase   = PH_IDLE;
              rx_mode = 1'b0;
            end
            default: ;
          endcase
        end
      end
    endcase
    if (produced > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endtask

  task automatic match_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: link byte mismatch on %s, expected %0h, actual %0h",
               $time, name, want, got);
      mismatches_o++;
    end
  endtask

  task automatic check_link_byte(result_t got);
    result_t want;
    if (expected_bytes.size() == 0) begin
      $display("%0t: unexpected link byte, expected none, actual %02h kind %0d",
               $time, got.out_byte, got.byte_kind);
      mismatches_o++;
      return;
    end
    want = expected_bytes.pop_front();
    checked_o++;
    match_field("out_byte", want.out_byte, got.out_byte);
    match_field("byte_kind", want.byte_kind, got.byte_kind);
    match_field("is_receive", want.is_receive, got.is_receive);
    match_field("payload_length", want.payload_length, got.payload_length);
    match_field("more_fragments", want.more_fragments, got.more_fragments);
    match_field("frame_end", want.frame_end, got.frame_end);
    match_field("crc_bad", want.crc_bad, got.crc_bad);
    match_field("last", want.last, got.last);
  endtask

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    checked_o     = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_bytes.delete();
      crc_acc     = CrcStart;
      len_left    = '0;
      phase       = PH_IDLE;
      rx_mode     = 1'b0;
      hdr_hi_hold = 8'h00;
    end else begin
      if (out_valid_i && !out_stall_i) check_link_byte(out_result_i);
      if (in_valid_i && !in_stall_i) predict_link_bytes(in_item_i);
    end
    outstanding_o = expected_bytes.size();
  end

endmodule

// ===== tb/crc_framed_link_codec_top_tb.sv =====
// Stimulus and verdict for the link codec. The checker beside the block does
// all prediction and comparison; this module only feeds items, paces the
// result side and decides the outcome.
module crc_framed_link_codec_top_tb import cflc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  item_t   in_item   = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t out_result;

  int mismatches;
  int outstanding;
  int checked;

  // Pacing knobs. Each side draws its wait per transfer from 0 up to its limit;
  // a limit of zero gives a stretch with no idling on that side.
  int gap_max   = 14;
  int stall_max = 14;

  // Set once by the stimulus to make the receiver hold off for a long stretch.
  bit hold_req  = 1'b0;

  int items_taken;
  int send_frames;
  int recv_frames;
  int damaged_frames;
  int random_start;

  crc_framed_link_codec_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_result)
  );

  link_byte_checker u_link_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_result_i  (out_result),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stimulus side CRC, used only to build received frames whose check bytes
  // are right (or deliberately spoilt).
  function automatic logic [15:0] link_crc(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    int i;
    c = acc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Mostly short frames, now and then a longer one; the upper six bits,
  // including the more-fragments flag, are random.
  function automatic logic [15:0] pick_header();
    logic [9:0] len;
    logic [5:0] upper;
    if ($urandom_range(0, 7) == 0) begin
      len = 10'($urandom_range(7, 40));
    end else begin
      len = 10'($urandom_range(0, 6));
    end
    upper = 6'($urandom());
    return {upper, len};
  endfunction

  // Offers one item after a random gap and holds it, unchanged, until the
  // block takes the transfer. The stall is read straight after the edge, so
  // it is the value that the edge itself saw. Only items that the block acts
  // on are counted towards the length of the run.
  task automatic offer(op_e op, logic [15:0] hdr, logic [7:0] d, bit counted);
    int gap;
    item_t it;
    gap = $urandom_range(0, gap_max);
    it.op          = op;
    it.header_word = hdr;
    it.data_byte   = d;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (counted) items_taken++;
  endtask

  // A complete outgoing frame: start with its header, then exactly as many
  // payload bytes as the header announces, so the block appends the CRC.
  task automatic send_frame(logic [15:0] hdr);
    int n;
    send_frames++;
    offer(OP_SEND_START, hdr, 8'($urandom()), 1'b1);
    for (n = 0; n < int'(hdr[PlenW-1:0]); n++) begin
      offer(OP_SEND_BYTE, 16'($urandom()), 8'($urandom()), 1'b1);
    end
  endtask

  // A complete incoming frame with a matching CRC. When damage is asked for,
  // one bit of one payload or CRC byte is flipped on the way in, which a
  // CRC-16 always catches, so the block must flag the frame end.
  task automatic recv_frame(logic [15:0] hdr, bit damage);
    logic [15:0] crc;
    logic [7:0]  b;
    int          len;
    int          spoil;
    int          n;
    len   = hdr[PlenW-1:0];
    spoil = damage ? $urandom_range(0, len + 1) : -1;
    recv_frames++;
    if (damage) damaged_frames++;
    offer(OP_RECV_START, 16'($urandom()), 8'($urandom()), 1'b1);
    crc = CrcStart;
    offer(OP_RECV_BYTE, 16'($urandom()), hdr[15:8], 1'b1);
    crc = link_crc(crc, hdr[15:8]);
    offer(OP_RECV_BYTE, 16'($urandom()), hdr[7:0], 1'b1);
    crc = link_crc(crc, hdr[7:0]);
    for (n = 0; n < len; n++) begin
      b   = 8'($urandom());
      crc = link_crc(crc, b);
      if (spoil == n) b ^= 8'(1 << $urandom_range(0, 7));
      offer(OP_RECV_BYTE, 16'($urandom()), b, 1'b1);
    end
    b = crc[15:8];
    if (spoil == len) b ^= 8'(1 << $urandom_range(0, 7));
    offer(OP_RECV_BYTE, 16'($urandom()), b, 1'b1);
    b = crc[7:0];
    if (spoil == len + 1) b ^= 8'(1 << $urandom_range(0, 7));
    offer(OP_RECV_BYTE, 16'($urandom()), b, 1'b1);
  endtask

  // Result side. Between transfers it stalls for a drawn number of cycles,
  // then drops the stall and waits for a transfer. Once, on request, the
  // hold-off is long enough for the block to fill up and stall its input.
  initial begin
    int  hold;
    bit  hold_taken;
    hold_taken = 1'b0;
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold       = 400;
      end else begin
        hold = $urandom_range(0, stall_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int pick;
    int n;
    int k;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part. An empty send gives all five bytes from one item.
    send_frame(16'h0000);
    // Every header bit set: longest length and more-fragments, then one
    // payload byte before a fresh start abandons the frame mid-payload.
    offer(OP_SEND_START, 16'hFFFF, 8'h00, 1'b1);
    offer(OP_SEND_BYTE, 16'h0000, 8'h00, 1'b1);
    send_frame(16'h0402);
    // Payload byte with no send payload open, and a received byte with no
    // receive frame open: both must be ignored.
    offer(OP_SEND_BYTE, 16'hFFFF, 8'h3C, 1'b0);
    offer(OP_RECV_BYTE, 16'hFFFF, 8'h55, 1'b0);
    // An empty received frame goes straight from header to CRC.
    recv_frame(16'h0000, 1'b0);
    // A received frame with more-fragments set and a spoilt byte.
    recv_frame(16'h0401, 1'b1);
    // A send byte during a receive is ignored; a send start abandons the
    // receive, after which received bytes are ignored again.
    offer(OP_RECV_START, 16'h0000, 8'hFF, 1'b1);
    offer(OP_RECV_BYTE, 16'h0000, 8'hFF, 1'b1);
    offer(OP_SEND_BYTE, 16'h0000, 8'h11, 1'b0);
    offer(OP_SEND_START, 16'h0001, 8'h00, 1'b1);
    offer(OP_RECV_BYTE, 16'h0000, 8'h00, 1'b0);
    offer(OP_SEND_BYTE, 16'h0000, 8'hFF, 1'b1);
    // A receive start in mid-receive, left at the longest length.
    offer(OP_RECV_START, 16'hFFFF, 8'h00, 1'b1);
    offer(OP_RECV_BYTE, 16'h0000, 8'hFF, 1'b1);
    offer(OP_RECV_START, 16'h0000, 8'h00, 1'b1);
    offer(OP_RECV_BYTE, 16'h0000, 8'hFF, 1'b1);
    offer(OP_RECV_BYTE, 16'h0000, 8'hFF, 1'b1);

    // Back pressure: the receiver holds off while the sender keeps offering
    // back to back, so the block has to stall its input.
    random_start = items_taken;
    hold_req     = 1'b1;
    gap_max      = 0;
    stall_max    = 0;
    for (n = 0; n < 3; n++) send_frame({6'($urandom()), 10'd6});

    // Random part: mostly well-formed frames with random content, the rest
    // truncated frames and loose items.
    while (items_taken - random_start < 130) begin
      case ($urandom_range(0, 5))
        0: begin
          gap_max   = 0;
          stall_max = 0;
        end
        1: begin
          gap_max   = 0;
          stall_max = 14;
        end
        2: begin
          gap_max   = 14;
          stall_max = 0;
        end
        default: begin
          gap_max   = 14;
          stall_max = 14;
        end
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: send_frame(pick_header());
        3, 4, 5: recv_frame(pick_header(), $urandom_range(0, 3) == 0);
        6: begin
          // Truncated frame; whatever starts next abandons it.
          k = $urandom_range(0, 3);
          if ($urandom_range(0, 1) == 1) begin
            offer(OP_SEND_START, {6'($urandom()), 10'($urandom_range(7, 1023))},
                  8'($urandom()), 1'b1);
            for (n = 0; n < k; n++) begin
              offer(OP_SEND_BYTE, 16'($urandom()), 8'($urandom()), 1'b1);
            end
          end else begin
            offer(OP_RECV_START, 16'($urandom()), 8'($urandom()), 1'b1);
            for (n = 0; n < k + 2; n++) begin
              offer(OP_RECV_BYTE, 16'($urandom()), 8'($urandom()), 1'b1);
            end
          end
        end
        7: begin
          // Loose items of any kind with random fields.
          k = $urandom_range(1, 3);
          for (n = 0; n < k; n++) begin
            offer(op_e'($urandom_range(0, 3)), 16'($urandom()), 8'($urandom()), 1'b0);
          end
        end
        8: begin
          // After a completed send, stray bytes of both kinds are ignored.
          send_frame(pick_header());
          offer(OP_SEND_BYTE, 16'($urandom()), 8'($urandom()), 1'b0);
          offer(OP_RECV_BYTE, 16'($urandom()), 8'($urandom()), 1'b0);
        end
        default: begin
          send_frame({6'($urandom()), 10'd0});
          recv_frame({6'($urandom()), 10'd0}, $urandom_range(0, 1) == 1);
        end
      endcase
    end
    in_valid <= 1'b0;

    // Let the last prediction land, drain every expected byte, then give the
    // block a few more cycles in case it produces something unasked for.
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Summary: %0d items acted on, %0d link bytes compared field by field.",
             items_taken, checked);
    $display("Summary: %0d send frames, %0d receive frames, %0d of them with a spoilt CRC.",
             send_frames, recv_frames, damaged_frames);
    if (mismatches == 0) begin
      $display("crc_framed_link_codec_top verification clean");
    end else begin
      $display("crc_framed_link_codec_top verification failed");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run can take.
  initial begin
    #2_000_000;
    $display("Timeout with %0d link bytes still expected.", outstanding);
    $display("crc_framed_link_codec_top verification failed");
    $finish;
  end

endmodule

// ===== crc_framed_link_codec_top.f =====
+incdir+rtl
rtl/cflc_pkg.sv
rtl/cflc_in_stage.sv
rtl/cflc_seq.sv
rtl/cflc_out_stage.sv
rtl/crc_framed_link_codec_top.sv
tb/link_byte_checker.sv
tb/crc_framed_link_codec_top_tb.sv
